### design/tcpg_pkg.sv
package tcpg_pkg;

  // Item kinds, shared by the input and result channels
  localparam logic KIND_TOUCH = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Cursor square limits
  localparam logic [5:0] SQUARE_MIN   = 6'd4;
  localparam logic [5:0] SQUARE_MAX   = 6'd32;
  localparam logic [5:0] SQUARE_STEP  = 6'd4;
  localparam logic [5:0] SQUARE_RESET = 6'd8;

  // Register reset values
  localparam logic [7:0] X_MIN_RESET = 8'hC9;
  localparam logic [7:0] X_MAX_RESET = 8'hF1;

  // Configuration register indexes
  localparam logic REG_X_MIN = 1'b0;
  localparam logic REG_X_MAX = 1'b1;

  localparam int NUM_KEYS    = 6;
  localparam int QUEUE_DEPTH = 2;

  // Key y bands, inclusive on both ends
  localparam logic [7:0] BAND_LOW  [NUM_KEYS] = '{8'h17, 8'h3D, 8'h62, 8'h88, 8'hAE, 8'hD3};
  localparam logic [7:0] BAND_HIGH [NUM_KEYS] = '{8'h33, 8'h58, 8'h7E, 8'hA4, 8'hC9, 8'hEF};

  // Colour index to RGB word
  localparam logic [30:0] PALETTE [8] = '{
    31'h00000000, 31'h03FF0000, 31'h7C007C00, 31'h7FFF7C00,
    31'h000003FF, 31'h03FF03FF, 31'h7C007FFF, 31'h7FFF7FFF
  };

  typedef enum logic [2:0] {
    KEY_ROW_UP,
    KEY_ROW_DOWN,
    KEY_COL_LEFT,
    KEY_COL_RIGHT,
    KEY_SIZE_UP,
    KEY_SIZE_DOWN,
    KEY_NONE
  } key_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic       kind;
    logic [5:0] lamps;
    logic [2:0] colour;
    logic       invert;
    logic       last;
  } item_t;

endpackage

### design/tcpg_front.sv
module tcpg_front
  import tcpg_pkg::*;
#(
  parameter int TILE_ROWS = 15,
  parameter int TILE_COLS = 20,
  parameter int TILE_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic       in_pen_down,
  input  logic [7:0] in_touch_x,
  input  logic [7:0] in_touch_y,
  input  logic       in_rising_edge,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  localparam int TRW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int TCW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int OW  = $clog2(TILE_SIZE);
  localparam logic [TRW-1:0] ROW_LAST = TRW'(TILE_ROWS - 1);
  localparam logic [TCW-1:0] COL_LAST = TCW'(TILE_COLS - 1);
  localparam logic [OW-1:0]  OFF_LAST = OW'(TILE_SIZE - 1);
  localparam logic [2:0]     ROW_STEP = 3'(TILE_COLS % 8);
  localparam logic signed [7:0] HALF_TILE = 8'(TILE_SIZE / 2);

  logic [7:0]     x_min_r, x_max_r;
  logic [TRW-1:0] cur_row_r, cur_row_nxt;
  logic [TCW-1:0] cur_col_r, cur_col_nxt;
  logic [5:0]     cur_sq_r, cur_sq_nxt;
  logic [TRW-1:0] tile_row_r, tile_row_nxt;
  logic [TCW-1:0] tile_col_r, tile_col_nxt;
  logic [OW-1:0]  off_row_r, off_row_nxt;
  logic [OW-1:0]  off_col_r, off_col_nxt;
  logic [2:0]     colour_r, colour_nxt;
  logic [2:0]     row_base_r, row_base_nxt;

  key_t              key;
  logic [5:0]        lamps;
  logic              transfer;
  logic              last;
  logic              invert;
  logic signed [7:0] win_lo, win_hi, orow_s, ocol_s;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign transfer   = in_valid && push_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= X_MIN_RESET;
      x_max_r <= X_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN: x_min_r <= cfg_data;
        REG_X_MAX: x_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the touched key from the column and the y bands
  always_comb begin
    key = KEY_NONE;
    if (in_pen_down && in_touch_x >= x_min_r && in_touch_x <= x_max_r) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (in_touch_y >= BAND_LOW[k] && in_touch_y <= BAND_HIGH[k]) begin
          key = key_t'(3'(k));
        end
      end
    end
    lamps = (key == KEY_NONE) ? 6'd0 : (6'd1 << key);
  end

  // Test the current pixel against the cursor window
  always_comb begin
    win_lo = HALF_TILE - 8'(cur_sq_r >> 1);
    win_hi = HALF_TILE + 8'(cur_sq_r >> 1);
    orow_s = 8'(off_row_r);
    ocol_s = 8'(off_col_r);
    invert = (tile_row_r == cur_row_r) && (tile_col_r == cur_col_r) &&
             (orow_s >= win_lo) && (orow_s < win_hi) &&
             (ocol_s >= win_lo) && (ocol_s < win_hi);
    last   = (tile_row_r == ROW_LAST) && (off_row_r == OFF_LAST) &&
             (tile_col_r == COL_LAST) && (off_col_r == OFF_LAST);
  end

  // Build the queue entry
  always_comb begin
    push_item.kind   = in_kind;
    push_item.lamps  = (in_kind == KIND_TOUCH) ? lamps : 6'd0;
    push_item.colour = colour_r;
    push_item.invert = invert;
    push_item.last   = (in_kind == KIND_PIXEL) && last;
  end

  // Cursor moves and scan advance
  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cur_sq_nxt   = cur_sq_r;
    tile_row_nxt = tile_row_r;
    tile_col_nxt = tile_col_r;
    off_row_nxt  = off_row_r;
    off_col_nxt  = off_col_r;
    colour_nxt   = colour_r;
    row_base_nxt = row_base_r;
    if (transfer) begin
      if (in_kind == KIND_TOUCH) begin
        if (in_rising_edge) begin
          case (key)
            KEY_ROW_UP:    if (cur_row_r != '0) cur_row_nxt = cur_row_r - 1'b1;
            KEY_ROW_DOWN:  if (cur_row_r != ROW_LAST) cur_row_nxt = cur_row_r + 1'b1;
            KEY_COL_LEFT:  if (cur_col_r != '0) cur_col_nxt = cur_col_r - 1'b1;
            KEY_COL_RIGHT: if (cur_col_r != COL_LAST) cur_col_nxt = cur_col_r + 1'b1;
            KEY_SIZE_UP:   if (cur_sq_r < SQUARE_MAX) cur_sq_nxt = cur_sq_r + SQUARE_STEP;
            KEY_SIZE_DOWN: if (cur_sq_r > SQUARE_MIN) cur_sq_nxt = cur_sq_r - SQUARE_STEP;
            default: ;
          endcase
          tile_row_nxt = '0;
          tile_col_nxt = '0;
          off_row_nxt  = '0;
          off_col_nxt  = '0;
          colour_nxt   = '0;
          row_base_nxt = '0;
        end
      end else if (off_col_r != OFF_LAST) begin
        off_col_nxt = off_col_r + 1'b1;
      end else if (tile_col_r != COL_LAST) begin
        off_col_nxt  = '0;
        tile_col_nxt = tile_col_r + 1'b1;
        colour_nxt   = colour_r + 3'd1;
      end else begin
        // Wrap to the start of the next line
        off_col_nxt  = '0;
        tile_col_nxt = '0;
        colour_nxt   = row_base_r;
        if (off_row_r != OFF_LAST) begin
          off_row_nxt = off_row_r + 1'b1;
        end else begin
          off_row_nxt = '0;
          if (tile_row_r != ROW_LAST) begin
            tile_row_nxt = tile_row_r + 1'b1;
            row_base_nxt = row_base_r + ROW_STEP;
            colour_nxt   = row_base_r + ROW_STEP;
          end else begin
            tile_row_nxt = '0;
            row_base_nxt = '0;
            colour_nxt   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      cur_sq_r   <= SQUARE_RESET;
      tile_row_r <= '0;
      tile_col_r <= '0;
      off_row_r  <= '0;
      off_col_r  <= '0;
      colour_r   <= '0;
      row_base_r <= '0;
    end else begin
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_sq_r   <= cur_sq_nxt;
      tile_row_r <= tile_row_nxt;
      tile_col_r <= tile_col_nxt;
      off_row_r  <= off_row_nxt;
      off_col_r  <= off_col_nxt;
      colour_r   <= colour_nxt;
      row_base_r <= row_base_nxt;
    end
  end

endmodule

### design/tcpg_queue.sv
module tcpg_queue
  import tcpg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  item_t         entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != COUNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("queue occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == COUNT_FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with occupancy");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push without pop did not grow the queue");

endmodule

### design/tcpg_back.sv
module tcpg_back
  import tcpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [5:0]  out_key_lamps,
  output logic [30:0] out_pixel_rgb,
  output logic        out_frame_last
);

  logic        valid_r, valid_nxt;
  logic        kind_r;
  logic [5:0]  lamps_r;
  logic [30:0] rgb_r;
  logic        last_r;
  logic        load;
  logic [2:0]  colour;

  assign pop_ready = !valid_r || out_ready;
  assign load      = pop_valid && pop_ready;
  assign colour    = pop_item.colour ^ {3{pop_item.invert}};

  // Hold the result until it is taken
  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  // Map colour through the palette into the output register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= pop_item.kind;
      lamps_r <= pop_item.lamps;
      rgb_r   <= (pop_item.kind == KIND_PIXEL) ? PALETTE[colour] : 31'd0;
      last_r  <= pop_item.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_key_lamps   = lamps_r;
  assign out_pixel_rgb   = rgb_r;
  assign out_frame_last  = last_r;

  a_lamps_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_key_lamps))
    else $error("more than one key lamp lit");

  a_lamp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_TOUCH) |-> (out_pixel_rgb == '0 && !out_frame_last))
    else $error("lamp result carries pixel fields");

  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_PIXEL) |-> (out_key_lamps == '0))
    else $error("pixel result carries key lamps");

endmodule

### design/touch_cursor_tile_pixel_generator.sv
// Each item is written into a queue entry when it transfers, and its result is then
// registered in the back's output register. Throughput: one item per cycle while
// out_ready holds, touch samples and pixel ticks alike; the front updates cursor and
// scan counters in the transfer cycle, the back maps the palette.
// A two-entry queue sits between them, and the result register lets input continue
// while a result waits on the output. Synchronous active-low reset clears the
// cursor (tile 0,0, square 8), restarts the scan and reloads the key column limits.
module touch_cursor_tile_pixel_generator
  import tcpg_pkg::*;
#(
  parameter int TILE_ROWS = 15,
  parameter int TILE_COLS = 20,
  parameter int TILE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic        in_pen_down,
  input  logic [7:0]  in_touch_x,
  input  logic [7:0]  in_touch_y,
  input  logic        in_rising_edge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [5:0]  out_key_lamps,
  output logic [30:0] out_pixel_rgb,
  output logic        out_frame_last
);

  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;
  item_t push_item, pop_item;

  tcpg_front #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .TILE_SIZE (TILE_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_pen_down    (in_pen_down),
    .in_touch_x     (in_touch_x),
    .in_touch_y     (in_touch_y),
    .in_rising_edge (in_rising_edge),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  tcpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tcpg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_key_lamps   (out_key_lamps),
    .out_pixel_rgb   (out_pixel_rgb),
    .out_frame_last  (out_frame_last)
  );

endmodule
